// File: rtl/core/tpp_pkg.sv
// ----------------------------------------------------------------------------
// Tile path parser package
// Shared constants and item types for the tile path parser core.
// ----------------------------------------------------------------------------
`default_nettype none

package tpp_pkg;

    localparam int ChWidth       = 8;
    localparam int PrefixWidth   = 8;
    localparam int CountWidth    = 4;
    localparam int ZoomWidth     = 7;
    localparam int CoordWidth    = 30;
    localparam int ZoomDigits    = 2;
    localparam int CoordDigits   = 9;
    localparam int OutDataWidth  = 72;
    localparam int OutUserWidth  = 2;

    localparam logic [ChWidth-1:0] ChSlash = 8'h2F;
    localparam logic [ChWidth-1:0] ChDot   = 8'h2E;
    localparam logic [ChWidth-1:0] ChP     = 8'h70;
    localparam logic [ChWidth-1:0] ChN     = 8'h6E;
    localparam logic [ChWidth-1:0] ChG     = 8'h67;
    localparam logic [ChWidth-1:0] ChJ     = 8'h6A;
    localparam logic [ChWidth-1:0] ChZero  = 8'h30;
    localparam logic [ChWidth-1:0] ChNine  = 8'h39;

    typedef struct packed {
        logic               last;
        logic [ChWidth-1:0] ch;
    } t_char;

    typedef struct packed {
        logic                  suffix_kind;
        logic [CoordWidth-1:0] y_coord;
        logic [CoordWidth-1:0] x_coord;
        logic [ZoomWidth-1:0]  zoom;
        logic                  matched;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/core/tpp_in_stage.sv
// ----------------------------------------------------------------------------
// Tile path parser input stage
// Registers one incoming character item and holds it until it is consumed.
// ----------------------------------------------------------------------------
`default_nettype none

module tpp_in_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire tpp_pkg::t_char i_char,
    input  wire logic           i_consume,
    output logic                o_valid,
    output tpp_pkg::t_char      o_char
);

    logic           r_valid;
    tpp_pkg::t_char r_char;

    assign o_ready = !r_valid || i_consume;
    assign o_valid = r_valid;
    assign o_char  = r_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_char <= i_char;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tpp_parser.sv
// ----------------------------------------------------------------------------
// Tile path parser step logic
// Holds the per-string match state and advances it by one character a step.
// ----------------------------------------------------------------------------
`default_nettype none

module tpp_parser (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [tpp_pkg::PrefixWidth-1:0]   i_cfg_wr_data,
    input  wire logic                              i_step,
    input  wire tpp_pkg::t_char                    i_char,
    output logic                                   o_fire,
    output tpp_pkg::t_result                       o_result
);

    typedef enum logic [3:0] {
        PH_SKIP, PH_ZOOM, PH_X, PH_Y, PH_SUF1, PH_SUF2, PH_SUF3, PH_DONE
    } t_phase;

    t_phase                               r_phase, n_phase;
    logic [tpp_pkg::PrefixWidth-1:0]      r_prefix_length;
    logic [tpp_pkg::PrefixWidth-1:0]      r_skip_count, n_skip_count;
    logic [tpp_pkg::CountWidth-1:0]       r_digit_count, n_digit_count;
    logic [tpp_pkg::ZoomWidth-1:0]        r_zoom_acc, n_zoom_acc;
    logic [tpp_pkg::CoordWidth-1:0]       r_x_acc, n_x_acc;
    logic [tpp_pkg::CoordWidth-1:0]       r_y_acc, n_y_acc;
    logic                                 r_is_jpg, n_is_jpg;

    t_phase                               w_phase;
    logic [tpp_pkg::CountWidth-1:0]       w_count;
    logic                                 w_is_digit;
    logic [3:0]                           w_digit;
    logic                                 w_match;
    logic                                 w_fail;
    logic [tpp_pkg::ChWidth-1:0]          w_suf2_ch;

    assign w_is_digit = (i_char.ch >= tpp_pkg::ChZero) && (i_char.ch <= tpp_pkg::ChNine);
    assign w_digit    = 4'(i_char.ch - tpp_pkg::ChZero);
    assign w_suf2_ch  = r_is_jpg ? tpp_pkg::ChP : tpp_pkg::ChN;

    always_comb begin
        n_phase       = r_phase;
        n_skip_count  = r_skip_count;
        n_digit_count = r_digit_count;
        n_zoom_acc    = r_zoom_acc;
        n_x_acc       = r_x_acc;
        n_y_acc       = r_y_acc;
        n_is_jpg      = r_is_jpg;
        w_match       = 1'b0;
        w_fail        = 1'b0;
        w_phase       = (r_phase == PH_SKIP) ? PH_ZOOM : r_phase;
        w_count       = (r_phase == PH_SKIP) ? '0 : r_digit_count;

        if (r_phase == PH_SKIP && r_skip_count < r_prefix_length) begin
            n_skip_count = r_skip_count + 1'b1;
        end else if (r_phase != PH_DONE) begin
            n_phase       = w_phase;
            n_digit_count = w_count;
            case (w_phase)
                PH_ZOOM: begin
                    if (w_is_digit && w_count < tpp_pkg::CountWidth'(tpp_pkg::ZoomDigits)) begin
                        n_zoom_acc    = tpp_pkg::ZoomWidth'({r_zoom_acc, 3'b000}
                                        + {r_zoom_acc, 1'b0} + w_digit);
                        n_digit_count = w_count + 1'b1;
                    end else if (i_char.ch == tpp_pkg::ChSlash && w_count != '0) begin
                        n_phase       = PH_X;
                        n_digit_count = '0;
                    end else begin
                        w_fail = 1'b1;
                    end
                end
                PH_X: begin
                    if (w_is_digit && w_count < tpp_pkg::CountWidth'(tpp_pkg::CoordDigits)) begin
                        n_x_acc       = tpp_pkg::CoordWidth'({r_x_acc, 3'b000}
                                        + {r_x_acc, 1'b0} + w_digit);
                        n_digit_count = w_count + 1'b1;
                    end else if (i_char.ch == tpp_pkg::ChSlash && w_count != '0) begin
                        n_phase       = PH_Y;
                        n_digit_count = '0;
                    end else begin
                        w_fail = 1'b1;
                    end
                end
                PH_Y: begin
                    if (w_is_digit && w_count < tpp_pkg::CountWidth'(tpp_pkg::CoordDigits)) begin
                        n_y_acc       = tpp_pkg::CoordWidth'({r_y_acc, 3'b000}
                                        + {r_y_acc, 1'b0} + w_digit);
                        n_digit_count = w_count + 1'b1;
                    end else if (i_char.ch == tpp_pkg::ChDot && w_count != '0) begin
                        n_phase       = PH_SUF1;
                        n_digit_count = '0;
                    end else begin
                        w_fail = 1'b1;
                    end
                end
                PH_SUF1: begin
                    if (i_char.ch == tpp_pkg::ChP) begin
                        n_is_jpg = 1'b0;
                        n_phase  = PH_SUF2;
                    end else if (i_char.ch == tpp_pkg::ChJ) begin
                        n_is_jpg = 1'b1;
                        n_phase  = PH_SUF2;
                    end else begin
                        w_fail = 1'b1;
                    end
                end
                PH_SUF2: begin
                    if (i_char.ch == w_suf2_ch) begin
                        n_phase = PH_SUF3;
                    end else begin
                        w_fail = 1'b1;
                    end
                end
                PH_SUF3: begin
                    if (i_char.ch == tpp_pkg::ChG) begin
                        w_match = 1'b1;
                    end else begin
                        w_fail = 1'b1;
                    end
                end
                default: begin
                    w_fail = 1'b1;
                end
            endcase
        end

        if (!w_match && i_char.last && r_phase != PH_DONE) begin
            w_fail = 1'b1;
        end

        o_fire               = w_match || w_fail;
        o_result.matched     = w_match;
        o_result.zoom        = w_match ? n_zoom_acc : '0;
        o_result.x_coord     = w_match ? n_x_acc : '0;
        o_result.y_coord     = w_match ? n_y_acc : '0;
        o_result.suffix_kind = w_match ? n_is_jpg : 1'b0;

        if (o_fire) begin
            n_phase = PH_DONE;
        end

        if (i_char.last) begin
            n_phase       = PH_SKIP;
            n_skip_count  = '0;
            n_digit_count = '0;
            n_zoom_acc    = '0;
            n_x_acc       = '0;
            n_y_acc       = '0;
            n_is_jpg      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_length <= '0;
            r_phase         <= PH_SKIP;
            r_skip_count    <= '0;
            r_digit_count   <= '0;
            r_zoom_acc      <= '0;
            r_x_acc         <= '0;
            r_y_acc         <= '0;
            r_is_jpg        <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_prefix_length <= i_cfg_wr_data;
            end
            if (i_step) begin
                r_phase       <= n_phase;
                r_skip_count  <= n_skip_count;
                r_digit_count <= n_digit_count;
                r_zoom_acc    <= n_zoom_acc;
                r_x_acc       <= n_x_acc;
                r_y_acc       <= n_y_acc;
                r_is_jpg      <= n_is_jpg;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tpp_out_stage.sv
// ----------------------------------------------------------------------------
// Tile path parser output stage
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tpp_out_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire tpp_pkg::t_result i_result,
    input  wire logic             i_ready,
    output logic                  o_valid,
    output logic                  o_free,
    output tpp_pkg::t_result      o_result
);

    logic             r_valid;
    tpp_pkg::t_result r_result;

    assign o_valid  = r_valid;
    assign o_free   = !r_valid || i_ready;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tile_path_parser_core.sv
// ----------------------------------------------------------------------------
// Tile path parser core
// Matches zoom/x/y.png or zoom/x/y.jpg after a configurable prefix and
// reports one result item per path string.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// s         in         i_s_tvalid/o_s_tready tdata ch, tlast last
// m         out        o_m_tvalid/i_m_tready tdata zoom,x,y; tuser matched,kind
// cfg       in         i_cfg_wr_en           i_cfg_wr_data prefix_length
//
// One character item is accepted per cycle unless a held result stalls the
// input. It is held in the input register, and its result is registered in
// the output stage when the character is consumed.
// A held result stalls the input only when the pending character itself
// produces a result. Reset is synchronous and returns the parser to the
// prefix skip phase.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_path_parser_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [tpp_pkg::PrefixWidth-1:0]    i_cfg_wr_data,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    input  wire logic [tpp_pkg::ChWidth-1:0]        i_s_tdata,   // [7:0] ch
    input  wire logic                               i_s_tlast,
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // [6:0] zoom, [36:7] x_coord, [66:37] y_coord
    output logic [tpp_pkg::OutDataWidth-1:0]        o_m_tdata,
    // [0] matched, [1] suffix_kind
    output logic [tpp_pkg::OutUserWidth-1:0]        o_m_tuser
);

    tpp_pkg::t_char   w_in_char;
    tpp_pkg::t_char   w_reg_char;
    tpp_pkg::t_result w_result;
    tpp_pkg::t_result w_out_result;
    logic             w_reg_valid;
    logic             w_fire;
    logic             w_out_free;
    logic             w_consume;

    assign w_in_char.ch   = i_s_tdata;
    assign w_in_char.last = i_s_tlast;
    assign w_consume      = w_reg_valid && (!w_fire || w_out_free);

    tpp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_char    (w_in_char),
        .i_consume (w_consume),
        .o_valid   (w_reg_valid),
        .o_char    (w_reg_char)
    );

    tpp_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (w_consume),
        .i_char        (w_reg_char),
        .o_fire        (w_fire),
        .o_result      (w_result)
    );

    tpp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_consume && w_fire),
        .i_result (w_result),
        .i_ready  (i_m_tready),
        .o_valid  (o_m_tvalid),
        .o_free   (w_out_free),
        .o_result (w_out_result)
    );

    assign o_m_tdata = {5'b00000, w_out_result.y_coord, w_out_result.x_coord,
                        w_out_result.zoom};
    assign o_m_tuser = {w_out_result.suffix_kind, w_out_result.matched};

`ifndef ASSERT_OFF
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata == '0 && !o_m_tuser[1])
        else $error("failure result carries nonzero fields");

    a_zoom_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata[6:0] <= 7'd99)
        else $error("matched zoom out of range");

    a_held_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_reg_valid && !w_consume |=> w_reg_valid && $stable(w_reg_char))
        else $error("pending character lost or overwritten");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_consume && w_fire |-> !o_m_tvalid || i_m_tready)
        else $error("result loaded over a pending result");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tile_path_parser_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tile path parser core testbench
// Streams path strings into the parser and checks every result item against
// a cycle-free parser model. The run starts with a table of hand-made paths
// and then sends random paths with random prefix lengths. Input bursts and
// output stalls are random, with one long output hold-off.
// ----------------------------------------------------------------------------
module tile_path_parser_core_test;

    localparam int LimitCycles = 200000;
    localparam int DrainCycles = 4;
    localparam int HoldCycles  = 500;

    typedef enum logic [2:0] {
        ScanPrefix, ScanZoom, ScanCol, ScanRow, ScanSuf1, ScanSuf2, ScanSuf3, ScanDone
    } t_scan;

    typedef byte unsigned t_char_q[$];

    typedef struct {
        string            path;
        int               pad;
        int               pfx;
        int               cut;
        int               pfx2;
        bit               typed;
        tpp_pkg::t_result tile;
    } t_dir_row;

    localparam tpp_pkg::t_result NoTile = '0;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [7:0]  i_cfg_wr_data = '0;
    logic        i_s_tvalid    = 1'b0;
    logic [7:0]  i_s_tdata     = '0;
    logic        i_s_tlast     = 1'b0;
    logic        i_m_tready    = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [71:0] o_m_tdata;
    logic [1:0]  o_m_tuser;

    // Parser model state.
    t_scan       scan_state;
    logic [7:0]  prefix_cfg;
    logic [7:0]  skip_seen;
    logic [3:0]  digits_in_field;
    logic [6:0]  zoom_val;
    logic [29:0] col_val;
    logic [29:0] row_val;
    logic        kind_jpg;
    bit          verdict_given;

    tpp_pkg::t_result tile_results_due[$];
    tpp_pkg::t_result last_tile_seen;
    int      error_count = 0;
    int      cycle_count = 0;
    int      gap_max     = 3;
    int      burst_left  = 0;

    int       hold_req   = 0;
    int       hold_seen  = 0;
    int       hold_left  = 0;
    int       mode_left  = 0;
    logic [1:0] stall_mode = '0;
    logic [7:0] rx_pattern = 8'b1011_0011;

    t_dir_row dir_rows[24];

    tile_path_parser_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tlast     (i_s_tlast),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic tpp_pkg::t_result tile_of(bit m, int unsigned z, int unsigned xc,
                                                 int unsigned yc, bit k);
        tpp_pkg::t_result t;
        t.matched     = m;
        t.zoom        = z[6:0];
        t.x_coord     = xc[29:0];
        t.y_coord     = yc[29:0];
        t.suffix_kind = k;
        return t;
    endfunction

    function automatic void clear_path_state();
        scan_state      = ScanPrefix;
        skip_seen       = '0;
        digits_in_field = '0;
        zoom_val        = '0;
        col_val         = '0;
        row_val         = '0;
        kind_jpg        = 1'b0;
        verdict_given   = 1'b0;
    endfunction

    // Returns 1 when the character produces a result item, placed in tile.
    function automatic bit parse_tile_char(input logic [7:0] c, input logic lst,
                                           output tpp_pkg::t_result tile);
        int         verdict;
        logic [7:0] dv;
        bit         dig;
        verdict = -1;
        dv      = c - tpp_pkg::ChZero;
        dig     = (c >= tpp_pkg::ChZero) && (c <= tpp_pkg::ChNine);
        tile    = NoTile;
        if (scan_state != ScanDone && !verdict_given) begin
            if (scan_state == ScanPrefix && skip_seen < prefix_cfg) begin
                skip_seen = skip_seen + 8'd1;
            end else begin
                if (scan_state == ScanPrefix) begin
                    scan_state      = ScanZoom;
                    digits_in_field = '0;
                end
                case (scan_state)
                    ScanZoom: begin
                        if (dig && digits_in_field < tpp_pkg::ZoomDigits) begin
                            zoom_val        = 7'(zoom_val * 7'd10 + dv[6:0]);
                            digits_in_field = digits_in_field + 4'd1;
                        end else if (c == tpp_pkg::ChSlash && digits_in_field != 0) begin
                            scan_state      = ScanCol;
                            digits_in_field = '0;
                        end else begin
                            verdict = 0;
                        end
                    end
                    ScanCol: begin
                        if (dig && digits_in_field < tpp_pkg::CoordDigits) begin
                            col_val         = 30'(col_val * 30'd10 + 30'(dv));
                            digits_in_field = digits_in_field + 4'd1;
                        end else if (c == tpp_pkg::ChSlash && digits_in_field != 0) begin
                            scan_state      = ScanRow;
                            digits_in_field = '0;
                        end else begin
                            verdict = 0;
                        end
                    end
                    ScanRow: begin
                        if (dig && digits_in_field < tpp_pkg::CoordDigits) begin
                            row_val         = 30'(row_val * 30'd10 + 30'(dv));
                            digits_in_field = digits_in_field + 4'd1;
                        end else if (c == tpp_pkg::ChDot && digits_in_field != 0) begin
                            scan_state      = ScanSuf1;
                            digits_in_field = '0;
                        end else begin
                            verdict = 0;
                        end
                    end
                    ScanSuf1: begin
                        if (c == tpp_pkg::ChP) begin
                            kind_jpg   = 1'b0;
                            scan_state = ScanSuf2;
                        end else if (c == tpp_pkg::ChJ) begin
                            kind_jpg   = 1'b1;
                            scan_state = ScanSuf2;
                        end else begin
                            verdict = 0;
                        end
                    end
                    ScanSuf2: begin
                        if (c == (kind_jpg ? tpp_pkg::ChP : tpp_pkg::ChN)) begin
                            scan_state = ScanSuf3;
                        end else begin
                            verdict = 0;
                        end
                    end
                    ScanSuf3: begin
                        verdict = (c == tpp_pkg::ChG) ? 1 : 0;
                    end
                    default: begin
                        verdict = 0;
                    end
                endcase
            end
        end
        if (verdict < 0 && lst && !verdict_given) begin
            verdict = 0;
        end
        if (verdict >= 0) begin
            if (verdict == 1) begin
                tile = tile_of(1'b1, zoom_val, col_val, row_val, kind_jpg);
            end
            verdict_given = 1'b1;
            scan_state    = ScanDone;
        end
        if (lst) begin
            clear_path_state();
        end
        return verdict >= 0;
    endfunction

    function automatic void check_field(string tag, string name, longint unsigned e,
                                        longint unsigned a);
        if (e != a) begin
            error_count++;
            $display("%0t: %s %s mismatch, expected %0d, actual %0d", $time, tag, name, e, a);
        end
    endfunction

    function automatic void compare_tile(string tag, tpp_pkg::t_result e,
                                         tpp_pkg::t_result a);
        check_field(tag, "matched", e.matched, a.matched);
        check_field(tag, "zoom", e.zoom, a.zoom);
        check_field(tag, "x_coord", e.x_coord, a.x_coord);
        check_field(tag, "y_coord", e.y_coord, a.y_coord);
        check_field(tag, "suffix_kind", e.suffix_kind, a.suffix_kind);
    endfunction

    // Model update and result check at every edge.
    always @(posedge i_clk) begin
        tpp_pkg::t_result got;
        tpp_pkg::t_result due;
        tpp_pkg::t_result tile;
        if (!i_rst_n) begin
            prefix_cfg = '0;
            clear_path_state();
            tile_results_due.delete();
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got.matched     = o_m_tuser[0];
                got.suffix_kind = o_m_tuser[1];
                got.zoom        = o_m_tdata[6:0];
                got.x_coord     = o_m_tdata[36:7];
                got.y_coord     = o_m_tdata[66:37];
                last_tile_seen  = got;
                if (tile_results_due.size() == 0) begin
                    error_count++;
                    $display({"%0t: result item with none expected, actual matched %0d",
                              " zoom %0d x %0d y %0d kind %0d"},
                             $time, got.matched, got.zoom, got.x_coord, got.y_coord,
                             got.suffix_kind);
                end else begin
                    due = tile_results_due.pop_front();
                    compare_tile("result", due, got);
                end
            end
            if (i_cfg_wr_en) begin
                prefix_cfg = i_cfg_wr_data;
            end
            if (i_s_tvalid && o_s_tready) begin
                if (parse_tile_char(i_s_tdata, i_s_tlast, tile)) begin
                    tile_results_due.push_back(tile);
                end
            end
        end
    end

    // Output side: stall modes that change now and then, and long hold-offs on request.
    always @(posedge i_clk) begin
        rx_pattern <= {rx_pattern[6:0], rx_pattern[7]};
        if (mode_left == 0) begin
            stall_mode <= 2'($urandom_range(0, 3));
            mode_left  <= $urandom_range(40, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        if (hold_req != hold_seen) begin
            hold_seen  <= hold_req;
            hold_left  <= HoldCycles;
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            case (stall_mode)
                2'd0:    i_m_tready <= 1'b1;
                2'd1:    i_m_tready <= 1'($urandom_range(0, 1));
                2'd2:    i_m_tready <= ($urandom_range(0, 3) == 0);
                default: i_m_tready <= rx_pattern[0];
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LimitCycles) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_char(input byte unsigned c, input bit lst);
        int gap;
        if (burst_left == 0) begin
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        i_s_tlast  <= lst;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        burst_left--;
    endtask

    task automatic send_run(input t_char_q q, input int from, input int upto);
        for (int i = from; i <= upto; i++) begin
            send_char(q[i], i == q.size() - 1);
        end
    endtask

    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tile_results_due.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_prefix(input int v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v[7:0];
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    function automatic void put_digits(ref t_char_q q, input int n);
        for (int i = 0; i < n; i++) begin
            q.push_back(8'(tpp_pkg::ChZero + $urandom_range(0, 9)));
        end
    endfunction

    // Mostly well-formed tile paths, some damaged, some pure noise.
    function automatic t_char_q build_tile_path(input int pfx);
        t_char_q q;
        int      n;
        int      pos;
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(0, 255)));
            return q;
        end
        for (int i = 0; i < pfx; i++) q.push_back(8'($urandom_range(0, 255)));
        put_digits(q, $urandom_range(1, tpp_pkg::ZoomDigits));
        q.push_back(tpp_pkg::ChSlash);
        put_digits(q, $urandom_range(1, tpp_pkg::CoordDigits));
        q.push_back(tpp_pkg::ChSlash);
        put_digits(q, $urandom_range(1, tpp_pkg::CoordDigits));
        q.push_back(tpp_pkg::ChDot);
        if ($urandom_range(0, 1) == 1) begin
            q.push_back(tpp_pkg::ChJ);
            q.push_back(tpp_pkg::ChP);
        end else begin
            q.push_back(tpp_pkg::ChP);
            q.push_back(tpp_pkg::ChN);
        end
        q.push_back(tpp_pkg::ChG);
        pos = $urandom_range(pfx, q.size() - 1);
        case ($urandom_range(0, 7))
            0: q[pos] = 8'($urandom_range(0, 255));
            1: begin
                n = $urandom_range(1, q.size());
                while (q.size() > n) void'(q.pop_back());
            end
            2: begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(0, 255)));
            end
            3: q.insert(pos, 8'(tpp_pkg::ChZero + $urandom_range(0, 9)));
            default: ;
        endcase
        return q;
    endfunction

    initial begin
        t_char_q q;
        int      pfx;
        int      ph;
        int      phase_chars;
        int      random_chars;

        dir_rows = '{
            '{"0/0/0.png", 0, 0, 0, 0, 1, tile_of(1, 0, 0, 0, 0)},
            '{"99/999999999/999999999.jpg", 0, 0, 0, 0, 1,
              tile_of(1, 99, 999999999, 999999999, 1)},
            '{"tiles7/12/34.png", 0, 5, 0, 0, 1, tile_of(1, 7, 12, 34, 0)},
            '{"1/2/3.jpg", 255, 255, 0, 0, 1, tile_of(1, 1, 2, 3, 1)},
            '{"123/1/1.png", 0, 0, 0, 0, 1, NoTile},
            '{"1/1234567890/1.png", 0, 0, 0, 0, 1, NoTile},
            '{"1/1/1234567890.png", 0, 0, 0, 0, 1, NoTile},
            '{"/1/1.png", 0, 0, 0, 0, 1, NoTile},
            '{"1//1.png", 0, 0, 0, 0, 1, NoTile},
            '{"1/1/.png", 0, 0, 0, 0, 1, NoTile},
            '{"5/6/7.gif", 0, 0, 0, 0, 1, NoTile},
            '{"5/6/7.ppg", 0, 0, 0, 0, 0, NoTile},
            '{"5/6/7.jng", 0, 0, 0, 0, 0, NoTile},
            '{"5/6/7.PNG", 0, 0, 0, 0, 0, NoTile},
            '{"5/6/7.jpgXYZ", 0, 0, 0, 0, 1, tile_of(1, 5, 6, 7, 1)},
            '{"5/6/7.pn", 0, 0, 0, 0, 1, NoTile},
            '{"5/6/7.pnx", 0, 0, 0, 0, 1, NoTile},
            '{"abc", 0, 10, 0, 0, 1, NoTile},
            '{"7", 0, 0, 0, 0, 1, NoTile},
            '{"1:/2/3.png", 0, 0, 0, 0, 0, NoTile},
            '{"12/34/56.png", 0, 3, 0, 0, 0, NoTile},
            '{"abcd9/8/7.png", 0, 6, 3, 4, 0, NoTile},
            '{"abc2/3/4.jpg", 0, 6, 3, 1, 0, NoTile},
            '{"xx42/0/9.png", 0, 2, 0, 0, 0, NoTile}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            q.delete();
            for (int i = 0; i < dir_rows[r].pad; i++) q.push_back(8'($urandom_range(0, 255)));
            for (int i = 0; i < dir_rows[r].path.len(); i++) q.push_back(dir_rows[r].path[i]);
            write_prefix(dir_rows[r].pfx);
            if (dir_rows[r].cut > 0) begin
                // The prefix length changes while the string is half sent.
                send_run(q, 0, dir_rows[r].cut - 1);
                settle();
                write_prefix(dir_rows[r].pfx2);
                send_run(q, dir_rows[r].cut, q.size() - 1);
            end else begin
                send_run(q, 0, q.size() - 1);
            end
            settle();
            if (dir_rows[r].typed) begin
                compare_tile($sformatf("path %s", dir_rows[r].path), dir_rows[r].tile,
                             last_tile_seen);
            end
        end

        random_chars = 0;
        ph = 0;
        while (random_chars < 250 || ph < 4) begin
            pfx = (ph == 0) ? 0 : (ph == 1) ? 255 : $urandom_range(0, 12);
            gap_max = (ph % 3 == 2) ? 0 : $urandom_range(1, 8);
            write_prefix(pfx);
            if (ph == 3) begin
                hold_req <= hold_req + 1;
            end
            phase_chars = 0;
            do begin
                q = build_tile_path(pfx);
                send_run(q, 0, q.size() - 1);
                phase_chars += q.size();
            end while (phase_chars < 40 && pfx < 200);
            random_chars += phase_chars;
            ph++;
            settle();
        end

        repeat (2 * DrainCycles) @(posedge i_clk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
